// ===== hw/rtl/plst_pkg.sv =====
// ----------------------------------------------------------------------------
// plst_pkg: shared definitions for the positional list
// Widths, request and status codes, sequencer states and the result-load
// bundle passed from the sequencer to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package plst_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int DATA_W       = 32;
   localparam int POS_W        = 7;
   localparam int CNT_OUT_W    = 7;
   localparam int REQ_W        = 2;

   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_DUMP_RD,
      S_DUMP_OUT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic                 load;
      status_type           status;
      logic [DATA_W-1:0]    value;
      logic [CNT_OUT_W-1:0] count;
      logic                 last;
   } rsp_load_type;

endpackage

`default_nettype wire

// ===== hw/rtl/positional_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete: ordered list with insert/delete at position
//
// Keeps up to CAPACITY signed 32-bit entries in a single-port-pair memory.
// Request channel (req_*): req_type 0 inserts req_value at req_position,
// 1 deletes the entry at req_position, 2 dumps the list. Positions are
// one-based. Result channel (rsp_*): status, entry value (dump only),
// entry count after the request and a last flag closing each request.
// Insert/delete give one result beat; a dump gives one beat per entry, or
// a single "empty" beat.
// Timing: one request at a time; req_ready is high only while idle.
// Entries are moved one place per read/write pair through the memory,
// and a dump reads each entry from the memory before giving its beat.
// The result beat sits in an output register; a stalled receiver holds the
// sequencer in its result step. Reset clears the count (empty list); the
// memory needs no clearing, as only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_delete #(
   parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [plst_pkg::REQ_W-1:0]           req_type,
   input  wire logic signed [plst_pkg::DATA_W-1:0]   req_value,
   input  wire logic [plst_pkg::POS_W-1:0]           req_position,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [1:0]                                rsp_status,
   output logic signed [plst_pkg::DATA_W-1:0]        rsp_entry_value,
   output logic [plst_pkg::CNT_OUT_W-1:0]            rsp_entry_count,
   output logic                                      rsp_last
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // captured request
   logic [plst_pkg::REQ_W-1:0]  op_ff;
   logic [plst_pkg::DATA_W-1:0] value_ff;
   logic [plst_pkg::POS_W-1:0]  pos_ff;

   // result register
   logic                           rsp_valid_ff;
   plst_pkg::status_type           rsp_status_ff;
   logic [plst_pkg::DATA_W-1:0]    rsp_value_ff;
   logic [plst_pkg::CNT_OUT_W-1:0] rsp_count_ff;
   logic                           rsp_last_ff;

   logic                        idle;
   logic                        req_accept;
   logic                        rsp_free;
   plst_pkg::rsp_load_type      rsp_load;
   logic                        mem_we, mem_re;
   logic [AW-1:0]               mem_waddr, mem_raddr;
   logic [plst_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

   assign req_ready  = idle;
   assign req_accept = req_valid && idle;
   // register free when empty or its beat leaves this cycle
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= req_type;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load.load) begin
         rsp_status_ff <= rsp_load.status;
         rsp_value_ff  <= rsp_load.value;
         rsp_count_ff  <= rsp_load.count;
         rsp_last_ff   <= rsp_load.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   plst_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .idle       (idle),
      .op         (op_ff),
      .op_value   (value_ff),
      .op_pos     (pos_ff),
      .rsp_free   (rsp_free),
      .rsp_load   (rsp_load),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   plst_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/plst_store.sv =====
// ----------------------------------------------------------------------------
// plst_store: list entry memory
// One write port and one read port; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_store #(
   parameter int DEPTH = plst_pkg::CAPACITY_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        we,
   input  wire logic [AW-1:0]               waddr,
   input  wire logic [plst_pkg::DATA_W-1:0] wdata,
   input  wire logic                        re,
   input  wire logic [AW-1:0]               raddr,
   output logic      [plst_pkg::DATA_W-1:0] rdata
);

   logic [plst_pkg::DATA_W-1:0] mem [DEPTH];
   logic [plst_pkg::DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/plst_ctrl.sv =====
// ----------------------------------------------------------------------------
// plst_ctrl: list sequencer
// Decodes a request, walks the shared index counter over the memory to
// move entries one place per read/write pair, keeps the entry count and
// issues result loads.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_ctrl #(
   parameter int CAPACITY = plst_pkg::CAPACITY_DEF,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_accept,
   output logic                                   idle,
   input  wire logic [plst_pkg::REQ_W-1:0]        op,
   input  wire logic [plst_pkg::DATA_W-1:0]       op_value,
   input  wire logic [plst_pkg::POS_W-1:0]        op_pos,
   input  wire logic                              rsp_free,
   output plst_pkg::rsp_load_type                 rsp_load,
   output logic                                   mem_we,
   output logic [AW-1:0]                          mem_waddr,
   output logic [plst_pkg::DATA_W-1:0]            mem_wdata,
   output logic                                   mem_re,
   output logic [AW-1:0]                          mem_raddr,
   input  wire logic [plst_pkg::DATA_W-1:0]       mem_rdata
);

   // compare width: holds count, position and their +/-2 without overflow
   localparam int KW = ((CW > plst_pkg::POS_W) ? CW : plst_pkg::POS_W) + 2;
   localparam logic [KW-1:0] CAP_K = KW'(CAPACITY);

   plst_pkg::state_type  state_ff, state_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        count_ff, count_in;
   plst_pkg::status_type status_ff, status_in;

   logic [KW-1:0] pos_k, cnt_k, idx_k;
   logic          ins_bad, is_full, del_bad, is_empty, is_insert, dump_last;
   logic [AW-1:0] pos_addr;

   assign pos_k     = KW'(op_pos);
   assign cnt_k     = KW'(count_ff);
   assign idx_k     = KW'(idx_ff);
   assign is_insert = (op == plst_pkg::REQ_INSERT);
   assign is_empty  = (count_ff == '0);
   assign ins_bad   = (op_pos == '0) || (pos_k > cnt_k + KW'(1));
   assign is_full   = (cnt_k >= CAP_K);
   assign del_bad   = (op_pos == '0) || (pos_k > cnt_k);
   assign dump_last = (idx_k + KW'(1) == cnt_k);
   assign pos_addr  = AW'(pos_k - KW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plst_pkg::S_IDLE: begin
            if (req_accept) begin
               state_in = plst_pkg::S_DECODE;
            end
         end
         plst_pkg::S_DECODE: begin
            case (op)
               plst_pkg::REQ_INSERT: begin
                  if (ins_bad || is_full) begin
                     state_in = plst_pkg::S_RESP;
                  end else if (cnt_k >= pos_k) begin
                     state_in = plst_pkg::S_SHIFT_RD;
                  end else begin
                     state_in = plst_pkg::S_PLACE;
                  end
               end
               plst_pkg::REQ_DELETE: begin
                  if (!is_empty && !del_bad && (pos_k < cnt_k)) begin
                     state_in = plst_pkg::S_SHIFT_RD;
                  end else begin
                     state_in = plst_pkg::S_RESP;
                  end
               end
               plst_pkg::REQ_DUMP: begin
                  state_in = is_empty ? plst_pkg::S_RESP : plst_pkg::S_DUMP_RD;
               end
               default: state_in = plst_pkg::S_RESP;
            endcase
         end
         plst_pkg::S_SHIFT_RD: state_in = plst_pkg::S_SHIFT_WR;
         plst_pkg::S_SHIFT_WR: begin
            if (is_insert) begin
               state_in = (idx_k > pos_k) ? plst_pkg::S_SHIFT_RD : plst_pkg::S_PLACE;
            end else begin
               state_in = (idx_k + KW'(2) < cnt_k) ? plst_pkg::S_SHIFT_RD
                                                   : plst_pkg::S_RESP;
            end
         end
         plst_pkg::S_PLACE:   state_in = plst_pkg::S_RESP;
         plst_pkg::S_DUMP_RD: state_in = plst_pkg::S_DUMP_OUT;
         plst_pkg::S_DUMP_OUT: begin
            if (rsp_free) begin
               state_in = dump_last ? plst_pkg::S_IDLE : plst_pkg::S_DUMP_RD;
            end
         end
         plst_pkg::S_RESP: begin
            if (rsp_free) begin
               state_in = plst_pkg::S_IDLE;
            end
         end
         default: state_in = plst_pkg::S_IDLE;
      endcase
   end

   // index counter, entry count and pending status
   always_comb begin
      idx_in    = idx_ff;
      count_in  = count_ff;
      status_in = status_ff;
      case (state_ff)
         plst_pkg::S_DECODE: begin
            status_in = plst_pkg::ST_DONE;
            case (op)
               plst_pkg::REQ_INSERT: begin
                  idx_in = AW'(count_ff);
                  if (ins_bad) begin
                     status_in = plst_pkg::ST_RANGE;
                  end else if (is_full) begin
                     status_in = plst_pkg::ST_FULL;
                  end
               end
               plst_pkg::REQ_DELETE: begin
                  idx_in = pos_addr;
                  if (is_empty) begin
                     status_in = plst_pkg::ST_EMPTY;
                  end else if (del_bad) begin
                     status_in = plst_pkg::ST_RANGE;
                  end else if (pos_k == cnt_k) begin
                     // deleting the tail: nothing to move
                     count_in = count_ff - CW'(1);
                  end
               end
               plst_pkg::REQ_DUMP: begin
                  idx_in = '0;
                  if (is_empty) begin
                     status_in = plst_pkg::ST_EMPTY;
                  end
               end
               default: status_in = plst_pkg::ST_RANGE;
            endcase
         end
         plst_pkg::S_SHIFT_WR: begin
            if (is_insert) begin
               idx_in = idx_ff - AW'(1);
            end else begin
               idx_in = idx_ff + AW'(1);
               if (!(idx_k + KW'(2) < cnt_k)) begin
                  count_in = count_ff - CW'(1);
               end
            end
         end
         plst_pkg::S_PLACE: count_in = count_ff + CW'(1);
         plst_pkg::S_DUMP_OUT: begin
            if (rsp_free && !dump_last) begin
               idx_in = idx_ff + AW'(1);
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      idle           = (state_ff == plst_pkg::S_IDLE);
      mem_we         = 1'b0;
      mem_waddr      = idx_ff;
      mem_wdata      = mem_rdata;
      mem_re         = 1'b0;
      mem_raddr      = idx_ff;
      rsp_load.load   = 1'b0;
      rsp_load.status = status_ff;
      rsp_load.value  = '0;
      rsp_load.count  = cnt_k[plst_pkg::CNT_OUT_W-1:0];
      rsp_load.last   = 1'b1;
      unique case (state_ff)
         plst_pkg::S_SHIFT_RD: begin
            mem_re    = 1'b1;
            mem_raddr = is_insert ? (idx_ff - AW'(1)) : (idx_ff + AW'(1));
         end
         plst_pkg::S_SHIFT_WR: begin
            mem_we = 1'b1;
         end
         plst_pkg::S_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = pos_addr;
            mem_wdata = op_value;
         end
         plst_pkg::S_DUMP_RD: begin
            mem_re = 1'b1;
         end
         plst_pkg::S_DUMP_OUT: begin
            rsp_load.load   = rsp_free;
            rsp_load.status = plst_pkg::ST_DONE;
            rsp_load.value  = mem_rdata;
            rsp_load.last   = dump_last;
         end
         plst_pkg::S_RESP: begin
            rsp_load.load = rsp_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plst_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      status_ff <= status_in;
   end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for positional_list_insert_delete
// Drives insert, delete, dump and unused requests through the req_ channel,
// keeps a shadow copy of the list to work out the result beats of every
// accepted request, and compares each rsp_ beat field by field in order.
// Sender runs in random bursts; receiver stalls on its own changing pattern.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int               DATA_W     = plst_pkg::DATA_W;
   localparam int               POS_W      = plst_pkg::POS_W;
   localparam int               CNT_OUT_W  = plst_pkg::CNT_OUT_W;
   localparam int               REQ_W      = plst_pkg::REQ_W;
   localparam int               LIST_DEPTH = plst_pkg::CAPACITY_DEF;
   localparam logic [REQ_W-1:0] REQ_SPARE  = 2'd3;   // unused request code

   // one expected result beat
   typedef struct {
      plst_pkg::status_type status;
      logic [DATA_W-1:0]    value;
      logic [CNT_OUT_W-1:0] count;
      logic                 last;
   } list_beat_type;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow list plus the queue of beats still owed by the block.
   // -------------------------------------------------------------------------
   class list_scoreboard;
      logic [DATA_W-1:0] entries [LIST_DEPTH];
      int                fill;
      list_beat_type     owed_beats [$];
      int                errors;
      int                beats_checked;
      int                peak_fill;
      int                kind_seen [4];
      int                status_seen [4];

      function new();
         fill = 0;
         errors = 0;
         beats_checked = 0;
         peak_fill = 0;
         foreach (kind_seen[k]) kind_seen[k] = 0;
         foreach (status_seen[k]) status_seen[k] = 0;
      endfunction

      function void owe(plst_pkg::status_type st, logic [DATA_W-1:0] val, logic lst);
         list_beat_type b;
         b.status = st;
         b.value  = val;
         b.count  = fill[CNT_OUT_W-1:0];
         b.last   = lst;
         owed_beats.push_back(b);
         status_seen[st]++;
      endfunction

      // Apply one accepted request to the shadow list and queue its beats.
      function void note_request(logic [REQ_W-1:0] kind, logic [DATA_W-1:0] val,
                                 logic [POS_W-1:0] pos);
         int p;
         p = int'(pos);
         kind_seen[kind]++;
         case (kind)
            plst_pkg::REQ_INSERT: begin
               // range check comes ahead of the full check
               if (p < 1 || p > fill + 1)
                  owe(plst_pkg::ST_RANGE, '0, 1'b1);
               else if (fill >= LIST_DEPTH)
                  owe(plst_pkg::ST_FULL, '0, 1'b1);
               else begin
                  for (int i = fill; i >= p; i--)
                     entries[i] = entries[i-1];
                  entries[p-1] = val;
                  fill++;
                  if (fill > peak_fill) peak_fill = fill;
                  owe(plst_pkg::ST_DONE, '0, 1'b1);
               end
            end
            plst_pkg::REQ_DELETE: begin
               if (fill == 0)
                  owe(plst_pkg::ST_EMPTY, '0, 1'b1);
               else if (p < 1 || p > fill)
                  owe(plst_pkg::ST_RANGE, '0, 1'b1);
               else begin
                  for (int i = p - 1; i + 1 < fill; i++)
                     entries[i] = entries[i+1];
                  fill--;
                  owe(plst_pkg::ST_DONE, '0, 1'b1);
               end
            end
            plst_pkg::REQ_DUMP: begin
               if (fill == 0)
                  owe(plst_pkg::ST_EMPTY, '0, 1'b1);
               else
                  for (int i = 0; i < fill; i++)
                     owe(plst_pkg::ST_DONE, entries[i], (i + 1 == fill));
            end
            default: owe(plst_pkg::ST_RANGE, '0, 1'b1);
         endcase
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task check_result(logic [1:0] st, logic [DATA_W-1:0] val,
                        logic [CNT_OUT_W-1:0] cnt, logic lst);
         list_beat_type b;
         beats_checked++;
         if (owed_beats.size() == 0) begin
            report($sformatf("unexpected beat status=%0d value=%h count=%0d last=%b",
                             st, val, cnt, lst));
         end else begin
            b = owed_beats.pop_front();
            if (st !== b.status)
               report($sformatf("status %0d, want %0d", st, b.status));
            if (val !== b.value)
               report($sformatf("entry_value %h, want %h", val, b.value));
            if (cnt !== b.count)
               report($sformatf("entry_count %0d, want %0d", cnt, b.count));
            if (lst !== b.last)
               report($sformatf("last %b, want %b", lst, b.last));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [REQ_W-1:0]         req_type = plst_pkg::REQ_INSERT;
   logic signed [DATA_W-1:0] req_value = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_entry_value;
   logic [CNT_OUT_W-1:0]     rsp_entry_count;
   logic                     rsp_last;

   positional_list_insert_delete dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

   list_scoreboard sb = new();

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop far above the slowest legal run (every request a full
   // 64-entry dump with long receiver stalls would still end well before it).
   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver: stall pattern switches between no stalls, short frequent
   // stalls and rare long ones, so back pressure lands mid-dump as well as
   // on single-beat answers. Changes at negedge only.
   // -------------------------------------------------------------------------
   int stall_mode  = 0;
   int mode_timer  = 0;
   int stall_left  = 0;

   always @(negedge clock) begin
      if (mode_timer == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_timer = $urandom_range(50, 300);
      end else
         mode_timer = mode_timer - 1;
      if (stall_left == 0) begin
         case (stall_mode)
            1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
            2: if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(4, 12);
            default: stall_left = 0;
         endcase
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else
         rsp_ready <= 1'b1;
   end

   // result beats are checked at the edge that accepts them
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_status, rsp_entry_value, rsp_entry_count, rsp_last);
   end

   // -------------------------------------------------------------------------
   // Sender: bursts of random length with random gaps. Every task below is
   // entered and left at a falling edge.
   // -------------------------------------------------------------------------
   int burst_left = 0;

   task automatic send_beat(logic [REQ_W-1:0] kind, logic [DATA_W-1:0] val,
                            logic [POS_W-1:0] pos);
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_value    <= val;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, val, pos);
      @(negedge clock);
   endtask

   task automatic issue(logic [REQ_W-1:0] kind, logic [DATA_W-1:0] val,
                        logic [POS_W-1:0] pos);
      int gap;
      if (burst_left == 0) begin
         // long runs with no gaps at all now and then
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      send_beat(kind, val, pos);
      burst_left--;
   endtask

   // hold valid low until the block has answered everything
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.owed_beats.size() != 0) @(negedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;   // most negative
         1:       return 32'h7FFF_FFFF;   // most positive
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // position for insert: mostly within 1..fill+1, else anything
   function automatic logic [POS_W-1:0] insert_pos();
      if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 127));
      return POS_W'($urandom_range(1, sb.fill + 1));
   endfunction

   function automatic logic [POS_W-1:0] delete_pos();
      if (sb.fill == 0 || $urandom_range(0, 9) == 0)
         return POS_W'($urandom_range(0, 127));
      return POS_W'($urandom_range(1, sb.fill));
   endfunction

   // one random request, weighted toward growing the list
   task automatic random_request();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         issue(plst_pkg::REQ_INSERT, pick_value(), insert_pos());
      else if (r < 80)
         issue(plst_pkg::REQ_DELETE, pick_value(), delete_pos());
      else if (r < 93)
         issue(plst_pkg::REQ_DUMP, pick_value(), POS_W'($urandom_range(0, 127)));
      else
         issue(REQ_SPARE, pick_value(), POS_W'($urandom_range(0, 127)));
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   int rand_items;

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed: empty list cases, range edges, front/middle/end edits
      issue(plst_pkg::REQ_DUMP,   '0, 7'd0);             // dump of empty list
      issue(plst_pkg::REQ_DELETE, '0, 7'd1);             // delete from empty
      issue(plst_pkg::REQ_DELETE, '0, 7'd0);             // empty wins over bad position
      issue(plst_pkg::REQ_INSERT, 32'h1234_5678, 7'd0);  // position zero
      issue(plst_pkg::REQ_INSERT, 32'h1234_5678, 7'd2);  // past count+1
      issue(plst_pkg::REQ_INSERT, 32'h8000_0000, 7'd1);
      issue(plst_pkg::REQ_INSERT, 32'h7FFF_FFFF, 7'd2);  // append at count+1
      issue(plst_pkg::REQ_INSERT, '0, 7'd1);             // at the front
      issue(plst_pkg::REQ_INSERT, '1, 7'd2);             // in the middle
      issue(plst_pkg::REQ_INSERT, 32'hA5A5_5A5A, 7'd127);
      issue(REQ_SPARE,            32'hFFFF_FFFF, 7'd5);  // unused request code
      issue(plst_pkg::REQ_DUMP,   '1, 7'd127);
      issue(plst_pkg::REQ_DELETE, '0, 7'd0);
      issue(plst_pkg::REQ_DELETE, '0, 7'd5);             // count+1
      issue(plst_pkg::REQ_DELETE, '0, 7'd127);
      issue(plst_pkg::REQ_DELETE, '0, 7'd2);             // middle
      issue(plst_pkg::REQ_DELETE, '0, 7'd3);             // last entry
      issue(plst_pkg::REQ_DUMP,   '0, 7'd0);
      issue(plst_pkg::REQ_DELETE, '0, 7'd1);             // first entry
      issue(plst_pkg::REQ_DELETE, '0, 7'd1);             // back to empty
      issue(plst_pkg::REQ_DUMP,   '0, 7'd0);

      // --- random mix
      rand_items = 0;
      repeat (90) begin
         random_request();
         rand_items++;
      end

      // sender holds off until every owed beat is back
      drain_results();

      // --- fill to capacity, then poke the full list
      while (sb.fill < LIST_DEPTH) begin
         issue(plst_pkg::REQ_INSERT, pick_value(),
               POS_W'($urandom_range(1, sb.fill + 1)));
         rand_items++;
      end
      issue(plst_pkg::REQ_INSERT, pick_value(), 7'd1);                  // full
      issue(plst_pkg::REQ_INSERT, pick_value(), POS_W'(LIST_DEPTH + 1)); // full, append slot
      issue(plst_pkg::REQ_INSERT, pick_value(), POS_W'(LIST_DEPTH + 2)); // range beats full
      issue(plst_pkg::REQ_DELETE, pick_value(), POS_W'(LIST_DEPTH + 1));
      issue(plst_pkg::REQ_DUMP,   pick_value(), POS_W'($urandom_range(0, 127)));
      rand_items += 5;

      // --- shrink with valid deletes, then mix again to the end
      while (sb.fill > 20) begin
         if ($urandom_range(0, 15) == 0)
            issue(plst_pkg::REQ_DUMP, pick_value(), POS_W'($urandom_range(0, 127)));
         else
            issue(plst_pkg::REQ_DELETE, pick_value(), POS_W'($urandom_range(1, sb.fill)));
         rand_items++;
      end
      while (rand_items < 230) begin
         random_request();
         rand_items++;
      end

      // --- wind down: all answers in, then quiet time for stray beats
      drain_results();
      repeat (300) @(negedge clock);
      if (sb.owed_beats.size() != 0)
         sb.report($sformatf("%0d beats never arrived", sb.owed_beats.size()));

      $display("Sent %0d inserts, %0d deletes, %0d dumps, %0d unused codes; %0d beats checked",
               sb.kind_seen[plst_pkg::REQ_INSERT], sb.kind_seen[plst_pkg::REQ_DELETE],
               sb.kind_seen[plst_pkg::REQ_DUMP], sb.kind_seen[REQ_SPARE],
               sb.beats_checked);
      $display("List peaked at %0d of %0d; done/range/full/empty answers: %0d/%0d/%0d/%0d",
               sb.peak_fill, LIST_DEPTH, sb.status_seen[plst_pkg::ST_DONE],
               sb.status_seen[plst_pkg::ST_RANGE], sb.status_seen[plst_pkg::ST_FULL],
               sb.status_seen[plst_pkg::ST_EMPTY]);
      if (sb.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
